// ===== rtl/daily_usage_ledger_macros.svh =====
// ---------------------------------------------------------------------------
// daily_usage_ledger_macros.svh
// assertion macros shared by the ledger checker
// ---------------------------------------------------------------------------
`ifndef DAILY_USAGE_LEDGER_MACROS_SVH
`define DAILY_USAGE_LEDGER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define DUL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ledger assertion failed");

// next-cycle implication
`define DUL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ledger assertion failed");

`endif

// ===== rtl/dul_pkg.sv =====
// ---------------------------------------------------------------------------
// dul_pkg
// types and constants of the daily usage ledger
// ---------------------------------------------------------------------------
package dul_pkg;

	localparam int SUM_W   = 21;
	localparam int QUOT_W  = 17;
	localparam int ADDR_W  = 2;

	localparam logic [15:0] REC_MAX    = 16'hFFFF;
	localparam logic [16:0] MS_PER_MIN = 17'd60000;
	localparam logic [15:0] MS_MAX     = 16'd59999;
	localparam logic [31:0] LOST_MAX   = 32'hFFFF_FFFF;

	localparam logic [ADDR_W-1:0] REG_WINDOW_ADDR = '0;

	typedef enum logic [1:0] {
		FUNC_ADD_MIN  = 2'd0,
		FUNC_ADD_MS   = 2'd1,
		FUNC_CLEAR    = 2'd2,
		FUNC_SET_LOST = 2'd3
	} dul_func_t;

	typedef struct packed {
		logic [31:0] key;
		logic [15:0] mins;
		logic [15:0] ms;
		logic [15:0] pg;
	} dul_rec_t;

	typedef struct packed {
		logic        find;
		logic        mark;
		logic        ins_up;
		logic        ins_down;
		logic        wr;
		logic [31:0] day;
		logic [15:0] wr_mins;
		logic [15:0] wr_ms;
		logic [15:0] wr_pg;
	} dul_ctl_t;

endpackage

// ===== rtl/dul_if.sv =====
// ---------------------------------------------------------------------------
// dul_req_if / dul_res_if
// request and result channels of the daily usage ledger
// ---------------------------------------------------------------------------
interface dul_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [31:0] day_id;
	logic [31:0] amount;
	logic [31:0] pages;

	modport source (output valid, output func, output day_id, output amount,
		output pages, input ready);
	modport sink (input valid, input func, input day_id, input amount,
		input pages, output ready);
endinterface

interface dul_res_if;
	logic        valid;
	logic        ready;
	logic [20:0] window_minutes;
	logic [20:0] window_pages;
	logic [31:0] lost_minutes_out;
	logic [31:0] lost_pages_out;

	modport source (output valid, output window_minutes, output window_pages,
		output lost_minutes_out, output lost_pages_out, input ready);
	modport sink (input valid, input window_minutes, input window_pages,
		input lost_minutes_out, input lost_pages_out, output ready);
endinterface

// ===== rtl/dul_div.sv =====
// ---------------------------------------------------------------------------
// dul_div
// split of a 32-bit millisecond count into minutes and leftover milliseconds
// ---------------------------------------------------------------------------
module dul_div import dul_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [31:0]       dividend,
	output logic              busy,
	output logic [QUOT_W-1:0] quot,
	output logic [15:0]       rem
);

	// floor(x / 60000) = floor((x >> 5) * RECIP >> 38) for any 32-bit x
	localparam int          PRE_SH = 5;
	localparam int          RSH    = 38;
	localparam logic [27:0] RECIP  = 28'd146601551;

	logic [1:0]        ph_q;
	logic [31:0]       dvd_q;
	logic [54:0]       prod_q;
	logic [QUOT_W-1:0] quot_q;
	logic [15:0]       rem_q;
	logic [QUOT_W-1:0] quot_c;
	logic [32:0]       back_c;

	assign quot_c = prod_q[RSH +: QUOT_W];
	assign back_c = 33'(quot_c) * 33'(MS_PER_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ph_q <= '0;
		else if (start)
			ph_q <= 2'b01;
		else
			ph_q <= {ph_q[0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (start)
			dvd_q <= dividend;
		if (ph_q[0])
			prod_q <= 55'(dvd_q[31:PRE_SH]) * 55'(RECIP);
		if (ph_q[1]) begin
			quot_q <= quot_c;
			rem_q  <= 16'(33'(dvd_q) - back_c);
		end
	end

	assign busy = |ph_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/dul_cell.sv =====
// ---------------------------------------------------------------------------
// dul_cell
// one record slot of the sorted day chain with its window sum stage
// ---------------------------------------------------------------------------
module dul_cell import dul_pkg::*; #(
	parameter int IDX = 0,
	parameter int CW  = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dul_ctl_t         ctl,
	input  logic [CW-1:0]    count,
	input  logic [CW-1:0]    start,
	input  dul_rec_t         left_rec,
	input  dul_rec_t         right_rec,
	input  logic             left_lt,
	input  logic             right_lt,
	input  logic [SUM_W-1:0] sum_in_min,
	input  logic [SUM_W-1:0] sum_in_pg,
	output dul_rec_t         rec,
	output logic             lt,
	output logic             hit,
	output logic             tgt,
	output logic [SUM_W-1:0] sum_min,
	output logic [SUM_W-1:0] sum_pg
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);
	localparam logic          FIRST  = (IDX == 0);

	dul_rec_t         rec_q;
	logic             tgt_q;
	logic [SUM_W-1:0] sum_min_q;
	logic [SUM_W-1:0] sum_pg_q;
	logic             valid;
	logic             incl;
	dul_rec_t         fresh;

	assign valid = MY_IDX < count;
	assign incl  = valid && (MY_IDX >= start);
	assign lt    = valid && (rec_q.key < ctl.day);
	assign hit   = valid && (rec_q.key == ctl.day);
	assign fresh = '{key: ctl.day, mins: '0, ms: '0, pg: '0};

	always_ff @(posedge clk) begin
		if (ctl.find && ctl.ins_up) begin
			if (!lt) begin
				if (FIRST || left_lt)
					rec_q <= fresh;
				else
					rec_q <= left_rec;
			end
		end else if (ctl.find && ctl.ins_down) begin
			if (right_lt)
				rec_q <= right_rec;
			else if (lt)
				rec_q <= fresh;
		end else if (ctl.wr && tgt_q) begin
			rec_q.mins <= ctl.wr_mins;
			rec_q.ms   <= ctl.wr_ms;
			rec_q.pg   <= ctl.wr_pg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q     <= 1'b0;
			sum_min_q <= '0;
			sum_pg_q  <= '0;
		end else begin
			if (ctl.find) begin
				if (ctl.ins_up)
					tgt_q <= !lt && (FIRST || left_lt);
				else if (ctl.ins_down)
					tgt_q <= lt && !right_lt;
				else
					tgt_q <= ctl.mark && hit;
			end
			sum_min_q <= sum_in_min + (incl ? SUM_W'(rec_q.mins) : '0);
			sum_pg_q  <= sum_in_pg + (incl ? SUM_W'(rec_q.pg) : '0);
		end
	end

	assign rec     = rec_q;
	assign tgt     = tgt_q;
	assign sum_min = sum_min_q;
	assign sum_pg  = sum_pg_q;

endmodule

// ===== rtl/daily_usage_ledger.sv =====
// ---------------------------------------------------------------------------
// daily_usage_ledger
// sorted per-day reading ledger with window totals and lost counters
// ---------------------------------------------------------------------------
// requests arrive on req (func, day_id, amount, pages); each one yields
// exactly one result on res with the window minute and page totals and the
// lost counters as they stand after the request.
// the records sit in a chain of DAYS cells kept in ascending day order; a
// lookup and any insert or eviction shift happen together across the
// chain, in the find state.
// after a request is taken the block runs the reciprocal millisecond split,
// the lookup/insert, the step that applies the sums, the ripple of the
// partial sums down the cell chain, and the load of the result register,
// in that order. one request is in work at a time; the next one is taken
// only once the result register has been loaded. the result register lets
// the next request be taken while a result waits; a stalled receiver only
// holds the block once a second result is ready. window_days is written
// over the APB port at address 0; the user must write it only while idle,
// and the block itself does not enforce this. reset empties the table and
// clears the lost counters and window_days.
// ---------------------------------------------------------------------------
module daily_usage_ledger import dul_pkg::*; #(
	parameter int DAYS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	dul_req_if.sink           req,
	dul_res_if.source         res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CW = $clog2(DAYS + 1);
	localparam int XW = (CW > 6) ? CW : 6;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_FIND  = 6'b000100,
		ST_APPLY = 6'b001000,
		ST_SUM   = 6'b010000,
		ST_DONE  = 6'b100000
	} st_t;

	st_t            state_q;
	dul_func_t      func_q;
	logic [31:0]    day_q;
	logic [31:0]    amount_q;
	logic [31:0]    pages_q;
	logic [5:0]     window_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  start_q;
	logic [CW-1:0]  sum_cnt_q;
	logic [31:0]    lost_min_q;
	logic [15:0]    lost_ms_q;
	logic [31:0]    lost_pg_q;
	logic           res_valid_q;
	logic [SUM_W-1:0] res_min_q;
	logic [SUM_W-1:0] res_pg_q;
	logic [31:0]    res_lmin_q;
	logic [31:0]    res_lpg_q;

	logic              div_busy;
	logic [QUOT_W-1:0] div_quot;
	logic [15:0]       div_rem;
	logic              req_acc;

	dul_ctl_t         ctl;
	dul_rec_t         recs    [DAYS];
	logic [SUM_W-1:0] smin_v  [DAYS];
	logic [SUM_W-1:0] spg_v   [DAYS];
	logic [DAYS-1:0]  lt_v;
	logic [DAYS-1:0]  hit_v;
	logic [DAYS-1:0]  tgt_v;
	dul_rec_t         sel;

	logic [15:0] pg_cl;
	logic [15:0] mins_cl;
	logic        active;
	logic        rec_path;
	logic        lost_path;
	logic        full;
	logic        any_hit;
	logic [16:0] ms_sum;
	logic        ms_carry;
	logic [15:0] ms_new;
	logic [17:0] quot_c;
	logic [17:0] rec_min_sum;
	logic        rec_over;
	logic [16:0] rec_min_add;
	logic [16:0] rec_pg_add;
	logic [32:0] lost_min_sum;
	logic [32:0] lost_min_add;
	logic [32:0] lost_pg_add;
	logic [CW-1:0] count_nx;
	logic [XW-1:0] count_x;
	logic [XW-1:0] window_x;

	assign req_acc   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_WINDOW_ADDR) ? {26'd0, window_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_q <= '0;
		else if (psel && penable && pwrite && (paddr == REG_WINDOW_ADDR))
			window_q <= pwdata[5:0];
	end

	dul_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_acc),
		.dividend (req.amount),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// request decode
	assign pg_cl     = (pages_q > 32'(REC_MAX)) ? REC_MAX : pages_q[15:0];
	assign mins_cl   = (amount_q > 32'(REC_MAX)) ? REC_MAX : amount_q[15:0];
	assign active    = ((func_q == FUNC_ADD_MIN) && (mins_cl != '0 || pg_cl != '0)) ||
		((func_q == FUNC_ADD_MS) && (amount_q != '0 || pg_cl != '0));
	assign rec_path  = active && (day_q != '0);
	assign lost_path = active && (day_q == '0);
	assign full      = (count_q == CW'(DAYS));
	assign any_hit   = |hit_v;

	always_comb begin
		sel = '0;
		for (int i = 0; i < DAYS; i++)
			if (tgt_v[i])
				sel = sel | recs[i];
	end

	// millisecond fold
	assign ms_sum      = 17'(lost_path ? lost_ms_q : sel.ms) + 17'(div_rem);
	assign ms_carry    = ms_sum >= MS_PER_MIN;
	assign ms_new      = 16'(ms_carry ? (ms_sum - MS_PER_MIN) : ms_sum);
	assign quot_c      = 18'(div_quot) + 18'(ms_carry);
	assign rec_min_sum = 18'(sel.mins) + quot_c;
	assign rec_over    = rec_min_sum > 18'(REC_MAX);
	assign rec_min_add = 17'(sel.mins) + 17'(mins_cl);
	assign rec_pg_add  = 17'(sel.pg) + 17'(pg_cl);
	assign lost_min_sum = 33'(lost_min_q) + 33'(quot_c);
	assign lost_min_add = 33'(lost_min_q) + 33'(mins_cl);
	assign lost_pg_add  = 33'(lost_pg_q) + 33'(pg_cl);

	always_comb begin
		ctl          = '0;
		ctl.find     = (state_q == ST_FIND);
		ctl.mark     = rec_path;
		ctl.ins_up   = rec_path && !any_hit && !full;
		ctl.ins_down = rec_path && !any_hit && full && lt_v[0];
		ctl.wr       = (state_q == ST_APPLY) && rec_path;
		ctl.day      = day_q;
		ctl.wr_pg    = rec_pg_add[16] ? REC_MAX : rec_pg_add[15:0];
		if (func_q == FUNC_ADD_MIN) begin
			ctl.wr_mins = rec_min_add[16] ? REC_MAX : rec_min_add[15:0];
			ctl.wr_ms   = sel.ms;
		end else begin
			ctl.wr_mins = rec_over ? REC_MAX : rec_min_sum[15:0];
			ctl.wr_ms   = rec_over ? MS_MAX : ms_new;
		end
	end

	genvar g;
	generate
		for (g = 0; g < DAYS; g++) begin : g_cell
			dul_rec_t         l_rec;
			dul_rec_t         r_rec;
			logic             l_lt;
			logic             r_lt;
			logic [SUM_W-1:0] r_min;
			logic [SUM_W-1:0] r_pg;
			if (g == 0) begin : g_head
				assign l_rec = '0;
				assign l_lt  = 1'b0;
			end else begin : g_mid
				assign l_rec = recs[g-1];
				assign l_lt  = lt_v[g-1];
			end
			if (g == DAYS - 1) begin : g_tail
				assign r_rec = '0;
				assign r_lt  = 1'b0;
				assign r_min = '0;
				assign r_pg  = '0;
			end else begin : g_body
				assign r_rec = recs[g+1];
				assign r_lt  = lt_v[g+1];
				assign r_min = smin_v[g+1];
				assign r_pg  = spg_v[g+1];
			end
			dul_cell #(.IDX(g), .CW(CW)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.count      (count_q),
				.start      (start_q),
				.left_rec   (l_rec),
				.right_rec  (r_rec),
				.left_lt    (l_lt),
				.right_lt   (r_lt),
				.sum_in_min (r_min),
				.sum_in_pg  (r_pg),
				.rec        (recs[g]),
				.lt         (lt_v[g]),
				.hit        (hit_v[g]),
				.tgt        (tgt_v[g]),
				.sum_min    (smin_v[g]),
				.sum_pg     (spg_v[g])
			);
		end
	endgenerate

	// window start from the count after this request
	assign count_nx = (func_q == FUNC_CLEAR) ? '0 : count_q;
	assign count_x  = XW'(count_nx);
	assign window_x = XW'(window_q);

	always_ff @(posedge clk) begin
		if (req_acc) begin
			func_q   <= dul_func_t'(req.func);
			day_q    <= req.day_id;
			amount_q <= req.amount;
			pages_q  <= req.pages;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			start_q     <= '0;
			sum_cnt_q   <= '0;
			lost_min_q  <= '0;
			lost_ms_q   <= '0;
			lost_pg_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_acc)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_busy)
						state_q <= ST_FIND;
				end
				ST_FIND: begin
					if (ctl.ins_up)
						count_q <= count_q + 1'b1;
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					case (func_q)
						FUNC_CLEAR: begin
							count_q    <= '0;
							lost_min_q <= '0;
							lost_ms_q  <= '0;
							lost_pg_q  <= '0;
						end
						FUNC_SET_LOST: begin
							lost_min_q <= amount_q;
							lost_pg_q  <= pages_q;
						end
						FUNC_ADD_MIN: begin
							if (lost_path) begin
								lost_min_q <= lost_min_add[32] ? LOST_MAX : lost_min_add[31:0];
								lost_pg_q  <= lost_pg_add[32] ? LOST_MAX : lost_pg_add[31:0];
							end
						end
						FUNC_ADD_MS: begin
							if (lost_path) begin
								lost_min_q <= lost_min_sum[32] ? LOST_MAX : lost_min_sum[31:0];
								lost_ms_q  <= lost_min_sum[32] ? MS_MAX : ms_new;
								lost_pg_q  <= lost_pg_add[32] ? LOST_MAX : lost_pg_add[31:0];
							end
						end
						default: begin
						end
					endcase
					if (window_x != '0 && window_x < count_x)
						start_q <= CW'(count_x - window_x);
					else
						start_q <= '0;
					sum_cnt_q <= '0;
					state_q   <= ST_SUM;
				end
				ST_SUM: begin
					sum_cnt_q <= sum_cnt_q + 1'b1;
					if (sum_cnt_q == CW'(DAYS - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!res_valid_q || res.ready)) begin
			res_min_q  <= smin_v[0];
			res_pg_q   <= spg_v[0];
			res_lmin_q <= lost_min_q;
			res_lpg_q  <= lost_pg_q;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.window_minutes   = res_min_q;
	assign res.window_pages     = res_pg_q;
	assign res.lost_minutes_out = res_lmin_q;
	assign res.lost_pages_out   = res_lpg_q;

endmodule

// ===== rtl/dul_checker.sv =====
// ---------------------------------------------------------------------------
// dul_checker
// port-level checks of the daily usage ledger, bound to the top level
// ---------------------------------------------------------------------------
`include "daily_usage_ledger_macros.svh"

module dul_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic res_valid,
	input logic res_ready
);

	logic req_acc;
	logic res_stall;

	assign req_acc   = req_valid && req_ready;
	assign res_stall = res_valid && !res_ready;

	// one request in work at a time
	`DUL_ASSERT_NXT(a_one_in_work, req_acc, !req_ready)
	// a result never shows up right after a request
	`DUL_ASSERT_IMP(a_no_early_result, $rose(res_valid), !$past(req_acc))
	// stalled result stays offered
	`DUL_ASSERT_NXT(a_res_hold, res_stall, res_valid)

endmodule

bind daily_usage_ledger dul_checker u_dul_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.res_valid (res.valid),
	.res_ready (res.ready)
);
